### sv/hsv_to_rgb_converter_core_assert.svh
// Assertion macros for the converter RTL.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define HSVRGB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define HSVRGB_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Consequence checked in the cycle after the trigger.
`define HSVRGB_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### sv/hsvrgb_pkg.sv
// Package for the HSV to RGB converter: widths, fixed-point constants and
// the request record passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps

package hsvrgb_pkg;

	// Field widths
	localparam int HUE_W  = 16;
	localparam int SAT_W  = 9;
	localparam int CH_W   = 8;
	localparam int FRAC_W = 13;
	localparam int T_W    = 21;
	localparam int SECT_W = 3;

	// Defaults for top-level parameters
	localparam int DEF_CHANNEL_BITS = 8;
	localparam int DEF_QUEUE_DEPTH  = 4;

	// Fixed-point constants
	localparam int HUE_SPAN_I = 7680;  // 60 degrees in 1/128 degree
	localparam int NUM_SECT   = 6;
	localparam logic [HUE_W-1:0]  HUE_FULL  = 16'd46080;
	localparam logic [FRAC_W-1:0] HUE_SPAN  = 13'd7680;
	localparam logic [SAT_W-1:0]  Q_ONE     = 9'd256;
	localparam int                Q_SHIFT   = 8;
	localparam logic [T_W-1:0]    T_ONE     = 21'd1966080;  // Q_ONE * HUE_SPAN

	// floor(x / (2^25 * 15)) is done as a shift by 25, then a multiply by
	// ceil(2^24 / 15) and a shift by 24 (exact for quotients below 1.19M).
	localparam int             DEN_SHIFT   = 25;
	localparam int             RECIP_W     = 21;
	localparam logic [RECIP_W-1:0] RECIP_15 = 21'd1118482;
	localparam int             RECIP_SHIFT = 24;

	// Hue sectors, named by the colors they sweep between
	typedef enum logic [SECT_W-1:0] {
		SECT_R_TO_Y = 3'd0,
		SECT_Y_TO_G = 3'd1,
		SECT_G_TO_C = 3'd2,
		SECT_C_TO_B = 3'd3,
		SECT_B_TO_M = 3'd4,
		SECT_M_TO_R = 3'd5
	} hsvrgb_sector_t;

	// Channel routing selected by the front end
	typedef struct packed {
		logic           gray;
		logic           black;
		hsvrgb_sector_t sector;
	} hsvrgb_route_t;

	// Classified request held in the queue
	typedef struct packed {
		hsvrgb_route_t     route;
		logic [FRAC_W-1:0] frac;
		logic [SAT_W-1:0]  sat;
		logic [SAT_W-1:0]  bri;
	} hsvrgb_item_t;

endpackage

### sv/hsvrgb_front.sv
// Front end: takes input requests, clamps saturation and brightness, and
// splits hue into sector and fraction. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_front (
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
	input  logic [hsvrgb_pkg::SAT_W-1:0] saturation,
	input  logic [hsvrgb_pkg::SAT_W-1:0] brightness,
	input  logic                         q_full,
	output logic                         push,
	output hsvrgb_pkg::hsvrgb_item_t     push_item
);
	import hsvrgb_pkg::*;

	logic [HUE_W-1:0]  hue_eff;
	logic [SAT_W-1:0]  sat_c;
	logic [SAT_W-1:0]  bri_c;
	logic [SECT_W-1:0] sect_cnt;
	logic [HUE_W-1:0]  sect_base;

	// Accept whenever the queue has room
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Clamp to 1.0 and fold a full turn onto zero
	assign sat_c   = (saturation > Q_ONE) ? Q_ONE : saturation;
	assign bri_c   = (brightness > Q_ONE) ? Q_ONE : brightness;
	assign hue_eff = (hue == HUE_FULL) ? '0 : hue;

	// Sector is the number of sector boundaries at or below the hue
	always_comb begin
		sect_cnt = '0;
		for (int k = 1; k < NUM_SECT; k++) begin
			if (hue_eff >= HUE_W'(HUE_SPAN_I * k))
				sect_cnt = sect_cnt + 1'b1;
		end
	end

	assign sect_base = HUE_W'(HUE_SPAN_I) * HUE_W'(sect_cnt);

	// Classified request
	always_comb begin
		push_item.route.gray   = (sat_c == '0);
		push_item.route.black  = (hue_eff >= HUE_FULL);
		push_item.route.sector = hsvrgb_sector_t'(sect_cnt);
		push_item.frac         = FRAC_W'(hue_eff - sect_base);
		push_item.sat          = sat_c;
		push_item.bri          = bri_c;
	end

endmodule

### sv/hsvrgb_queue.sv
// Small register FIFO between the front and back ends.
// Depends on hsvrgb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_core_assert.svh"

module hsvrgb_queue #(
	parameter int DEPTH = hsvrgb_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  hsvrgb_pkg::hsvrgb_item_t push_item,
	output logic                     full,
	input  logic                     pop,
	output logic                     head_valid,
	output hsvrgb_pkg::hsvrgb_item_t head_item
);
	import hsvrgb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hsvrgb_item_t     entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	`HSVRGB_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "queue count above depth")
	`HSVRGB_ASSERT_IMPL(a_no_push_full, full, !push, "push into full queue")
	`HSVRGB_ASSERT_IMPL(a_no_pop_empty, pop, head_valid, "pop from empty queue")
	`HSVRGB_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue count did not advance on push")

endmodule

### sv/hsvrgb_back.sv
// Back end: four-stage arithmetic pipeline that scales brightness by the
// sector values and routes them to red, green and blue. Depends on hsvrgb_pkg.
`timescale 1ns / 1ps

module hsvrgb_back #(
	parameter int CHANNEL_BITS = hsvrgb_pkg::DEF_CHANNEL_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  hsvrgb_pkg::hsvrgb_item_t    head_item,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [hsvrgb_pkg::CH_W-1:0] red,
	output logic [hsvrgb_pkg::CH_W-1:0] green,
	output logic [hsvrgb_pkg::CH_W-1:0] blue
);
	import hsvrgb_pkg::*;

	localparam int BF_W  = CHANNEL_BITS + SAT_W;      // FULL * brightness
	localparam int LO_W  = 11;
	localparam int HI_W  = T_W - LO_W;
	localparam int PL_W  = BF_W + LO_W;
	localparam int PH_W  = BF_W + HI_W;
	localparam int SUM_W = BF_W + T_W;
	localparam int AA_W  = BF_W + SAT_W;
	localparam int Q_W   = SUM_W - DEN_SHIFT;
	localparam int MUL_W = Q_W + RECIP_W;
	localparam int VAL_W = (CHANNEL_BITS + 2 > CH_W) ? CHANNEL_BITS + 2 : CH_W;
	localparam logic [CHANNEL_BITS-1:0] FULL_C = {CHANNEL_BITS{1'b1}};

	logic adv;

	logic              v_s1, v_s2, v_s3, v_s4;
	hsvrgb_route_t     route_s1, route_s2, route_s3;
	logic [BF_W-1:0]   bfull_s1;
	logic [T_W-1:0]    ub_s1, uc_s1;
	logic [SAT_W-1:0]  invs_s1;
	logic [PL_W-1:0]   pbl_s2, pcl_s2;
	logic [PH_W-1:0]   pbh_s2, pch_s2;
	logic [AA_W-1:0]   aap_s2;
	logic [VAL_W-1:0]  full_s2, full_s3, aa_s3;
	logic [Q_W-1:0]    qb_s3, qc_s3;
	logic [CH_W-1:0]   red_s4, green_s4, blue_s4;

	logic [T_W-1:0]    tb, tc;
	logic [SUM_W-1:0]  sumb, sumc;
	logic [MUL_W-1:0]  mb, mc;
	logic [VAL_W-1:0]  bb, cc;
	logic [VAL_W-1:0]  r_val, g_val, b_val;

	// Whole pipeline moves when the output slot is free or being taken
	assign adv       = !v_s4 || out_ready;
	assign pop       = adv && head_valid;
	assign out_valid = v_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1: FULL * B and the two saturation-fraction products
	always_ff @(posedge clk) begin
		if (adv) begin
			route_s1 <= head_item.route;
			bfull_s1 <= BF_W'(FULL_C) * BF_W'(head_item.bri);
			ub_s1    <= T_W'(head_item.sat) * T_W'(head_item.frac);
			uc_s1    <= T_W'(head_item.sat) * T_W'(HUE_SPAN - head_item.frac);
			invs_s1  <= Q_ONE - head_item.sat;
		end
	end

	// Stage 2: split products of FULL * B with (1 - S f) and (1 - S (1 - f)), plus FULL * B * (1 - S)
	assign tb = T_ONE - ub_s1;
	assign tc = T_ONE - uc_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			route_s2 <= route_s1;
			pbl_s2   <= PL_W'(bfull_s1) * PL_W'(tb[LO_W-1:0]);
			pbh_s2   <= PH_W'(bfull_s1) * PH_W'(tb[T_W-1:LO_W]);
			pcl_s2   <= PL_W'(bfull_s1) * PL_W'(tc[LO_W-1:0]);
			pch_s2   <= PH_W'(bfull_s1) * PH_W'(tc[T_W-1:LO_W]);
			aap_s2   <= AA_W'(bfull_s1) * AA_W'(invs_s1);
			full_s2  <= VAL_W'(bfull_s1[BF_W-1:Q_SHIFT]);
		end
	end

	// Stage 3: recombine halves and drop the power-of-two part of the divisor
	assign sumb = SUM_W'(pbl_s2) + (SUM_W'(pbh_s2) << LO_W);
	assign sumc = SUM_W'(pcl_s2) + (SUM_W'(pch_s2) << LO_W);

	always_ff @(posedge clk) begin
		if (adv) begin
			route_s3 <= route_s2;
			qb_s3    <= sumb[SUM_W-1:DEN_SHIFT];
			qc_s3    <= sumc[SUM_W-1:DEN_SHIFT];
			aa_s3    <= VAL_W'(aap_s2[AA_W-1:2*Q_SHIFT]);
			full_s3  <= full_s2;
		end
	end

	// Stage 4: divide by 15 through the reciprocal, then route channels
	assign mb = MUL_W'(qb_s3) * MUL_W'(RECIP_15);
	assign mc = MUL_W'(qc_s3) * MUL_W'(RECIP_15);
	assign bb = VAL_W'(mb[MUL_W-1:RECIP_SHIFT]);
	assign cc = VAL_W'(mc[MUL_W-1:RECIP_SHIFT]);

	always_comb begin
		if (route_s3.gray) begin
			r_val = full_s3;
			g_val = full_s3;
			b_val = full_s3;
		end else if (route_s3.black) begin
			r_val = '0;
			g_val = '0;
			b_val = '0;
		end else begin
			unique case (route_s3.sector)
				SECT_R_TO_Y: begin r_val = full_s3; g_val = cc;      b_val = aa_s3;   end
				SECT_Y_TO_G: begin r_val = bb;      g_val = full_s3; b_val = aa_s3;   end
				SECT_G_TO_C: begin r_val = aa_s3;   g_val = full_s3; b_val = cc;      end
				SECT_C_TO_B: begin r_val = aa_s3;   g_val = bb;      b_val = full_s3; end
				SECT_B_TO_M: begin r_val = cc;      g_val = aa_s3;   b_val = full_s3; end
				SECT_M_TO_R: begin r_val = full_s3; g_val = aa_s3;   b_val = bb;      end
				default: begin
					r_val = '0;
					g_val = '0;
					b_val = '0;
				end
			endcase
		end
	end

	// Output register, low channel bits
	always_ff @(posedge clk) begin
		if (adv) begin
			red_s4   <= r_val[CH_W-1:0];
			green_s4 <= g_val[CH_W-1:0];
			blue_s4  <= b_val[CH_W-1:0];
		end
	end

endmodule

### sv/hsv_to_rgb_converter_core.sv
// HSV to RGB converter. Takes one hue/saturation/brightness request per cycle
// while in_ready is high (hue in 1/128 degree, saturation and brightness
// Q1.8 with 256 = 1.0) and returns red, green and blue as
// floor((2^CHANNEL_BITS - 1) * value), low 8 bits. Sustained rate is one
// request per clock cycle while the output is not stalled; a result passes
// through the request queue and then the four arithmetic pipeline registers
// on its way out. A QUEUE_DEPTH-entry queue sits between the classifier and
// the pipeline, so input keeps being accepted while the output is stalled
// until the queue fills; the pipeline itself moves only when its output
// register is empty or being read.
// Depends on hsvrgb_pkg, hsvrgb_front, hsvrgb_queue and hsvrgb_back.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core #(
	parameter int CHANNEL_BITS = hsvrgb_pkg::DEF_CHANNEL_BITS,
	parameter int QUEUE_DEPTH  = hsvrgb_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [hsvrgb_pkg::HUE_W-1:0] hue,
	input  logic [hsvrgb_pkg::SAT_W-1:0] saturation,
	input  logic [hsvrgb_pkg::SAT_W-1:0] brightness,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hsvrgb_pkg::CH_W-1:0]  red,
	output logic [hsvrgb_pkg::CH_W-1:0]  green,
	output logic [hsvrgb_pkg::CH_W-1:0]  blue
);
	import hsvrgb_pkg::*;

	logic         push;
	logic         q_full;
	hsvrgb_item_t push_item;
	logic         pop;
	logic         head_valid;
	hsvrgb_item_t head_item;

	// Request classification
	hsvrgb_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	// Decoupling queue
	hsvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Arithmetic pipeline
	hsvrgb_back #(
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

endmodule
